// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------
// assert_macros
// Shared concurrent assertion macros, sampled on clk, off during reset.
// ----------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequence must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ccp_pkg.sv =====
// ----------------------------------------------------------------------
// ccp_pkg
// Widths, codes and shared types of the cross-channel pooling block.
// ----------------------------------------------------------------------
package ccp_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int CH_BITS          = 10;
    localparam int CNT_BITS         = 11;
    localparam int LEN_BITS         = 7;
    localparam int WIN_LIMIT_BITS   = 6;
    localparam int SUM_BITS         = SAMPLE_BITS + WIN_LIMIT_BITS;
    localparam int MAX_CHANNELS     = 1024;
    localparam int DEF_OPEN_WINDOWS = 64;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int CFG_DATA_BITS    = 11;
    localparam int OUT_TDATA_BITS   = 40;

    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_AVG = 1'b1;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] acc;
        logic [CH_BITS-1:0]         winner;
        logic [CH_BITS-1:0]         index;
        logic [LEN_BITS-1:0]        len;
        logic                       done;
    } ccp_window_t;

    typedef struct packed {
        logic                          step;
        logic                          flush;
        logic                          mode;
        logic                          insert;
        logic                          direct;
        logic                          last_ch;
        logic [LEN_BITS-1:0]           ins_cell;
        logic [CH_BITS-1:0]            channel;
        logic signed [SAMPLE_BITS-1:0] sample;
        ccp_window_t                   seed;
    } ccp_ctrl_t;

endpackage

// ===== hdl/ccp_ctrl.sv =====
// ----------------------------------------------------------------------
// ccp_ctrl
// Configuration registers, channel counter and window opening logic.
// ----------------------------------------------------------------------
`include "assert_macros.svh"

module ccp_ctrl import ccp_pkg::*;
#(
    parameter int MAX_OPEN_WINDOWS = DEF_OPEN_WINDOWS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
    input  logic                          step,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output ccp_ctrl_t                     ctl
);

    localparam logic [CFG_INDEX_BITS-1:0] REG_POOL_MODE     = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_STEP   = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = CFG_INDEX_BITS'(3);

    logic                pool_mode_reg;
    logic [LEN_BITS-1:0] window_length_reg;
    logic [LEN_BITS-1:0] window_step_reg;
    logic [CNT_BITS-1:0] channel_count_reg;

    logic [CH_BITS-1:0]  channel_reg, channel_next;
    logic [CNT_BITS-1:0] next_start_reg, next_start_next;
    logic [CH_BITS-1:0]  window_index_reg, window_index_next;
    logic                ended_reg, ended_next;

    logic [LEN_BITS-1:0] k_eff;
    logic [LEN_BITS-1:0] s_eff;
    logic [CNT_BITS-1:0] n_eff;
    logic [CNT_BITS-1:0] remaining;
    logic [LEN_BITS-1:0] win_len;
    logic                is_start;
    logic                close_win;
    logic                last_ch;

    // clamp register values to their usable ranges
    always_comb
    begin
        if (window_length_reg == '0)
            k_eff = LEN_BITS'(1);
        else if (window_length_reg > LEN_BITS'(MAX_OPEN_WINDOWS))
            k_eff = LEN_BITS'(MAX_OPEN_WINDOWS);
        else
            k_eff = window_length_reg;

        s_eff = (window_step_reg == '0) ? LEN_BITS'(1) : window_step_reg;

        if (channel_count_reg == '0)
            n_eff = CNT_BITS'(1);
        else if (channel_count_reg > CNT_BITS'(MAX_CHANNELS))
            n_eff = CNT_BITS'(MAX_CHANNELS);
        else
            n_eff = channel_count_reg;
    end

    always_comb
    begin
        remaining = n_eff - CNT_BITS'(channel_reg);
        win_len   = (CNT_BITS'(k_eff) <= remaining) ? k_eff : LEN_BITS'(remaining);
        is_start  = !ended_reg && (CNT_BITS'(channel_reg) == next_start_reg);
        close_win = (CNT_BITS'(channel_reg) + CNT_BITS'(k_eff) >= n_eff)
                 || (CNT_BITS'(channel_reg) + CNT_BITS'(s_eff) >= n_eff);
        last_ch   = (CNT_BITS'(channel_reg) == n_eff - CNT_BITS'(1));
    end

    always_comb
    begin
        channel_next      = channel_reg;
        next_start_next   = next_start_reg;
        window_index_next = window_index_reg;
        ended_next        = ended_reg;
        if (step)
        begin
            if (is_start)
            begin
                next_start_next   = next_start_reg + CNT_BITS'(s_eff);
                window_index_next = window_index_reg + CH_BITS'(1);
                ended_next        = close_win;
            end
            if (last_ch)
            begin
                channel_next      = '0;
                next_start_next   = '0;
                window_index_next = '0;
                ended_next        = 1'b0;
            end
            else
            begin
                channel_next = channel_reg + CH_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_mode_reg     <= MODE_MAX;
            window_length_reg <= LEN_BITS'(2);
            window_step_reg   <= LEN_BITS'(2);
            channel_count_reg <= CNT_BITS'(64);
            channel_reg       <= '0;
            next_start_reg    <= '0;
            window_index_reg  <= '0;
            ended_reg         <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POOL_MODE:     pool_mode_reg     <= cfg_wdata[0];
                REG_WINDOW_LENGTH: window_length_reg <= cfg_wdata[LEN_BITS-1:0];
                REG_WINDOW_STEP:   window_step_reg   <= cfg_wdata[LEN_BITS-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata[CNT_BITS-1:0];
            endcase
            // any write restarts the pixel
            channel_reg      <= '0;
            next_start_reg   <= '0;
            window_index_reg <= '0;
            ended_reg        <= 1'b0;
        end
        else
        begin
            channel_reg      <= channel_next;
            next_start_reg   <= next_start_next;
            window_index_reg <= window_index_next;
            ended_reg        <= ended_next;
        end
    end

    always_comb
    begin
        ctl.step        = step;
        ctl.flush       = cfg_we;
        ctl.mode        = pool_mode_reg;
        ctl.insert      = is_start;
        ctl.direct      = (win_len == LEN_BITS'(1));
        ctl.last_ch     = last_ch;
        ctl.ins_cell    = win_len - LEN_BITS'(2);
        ctl.channel     = channel_reg;
        ctl.sample      = sample;
        ctl.seed.acc    = SUM_BITS'(sample);
        ctl.seed.winner = channel_reg;
        ctl.seed.index  = window_index_reg;
        ctl.seed.len    = win_len;
        ctl.seed.done   = close_win;
    end

    `ASSERT_ALWAYS(a_channel_range, CNT_BITS'(channel_reg) < n_eff, "channel beyond count")

endmodule

// ===== hdl/ccp_cell.sv =====
// ----------------------------------------------------------------------
// ccp_cell
// One open pooling window; absorbs the current word and hands the
// updated window to the neighbor one step closer to completion.
// ----------------------------------------------------------------------
`include "assert_macros.svh"

module ccp_cell import ccp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ccp_ctrl_t   ctl,
    input  logic        ins_here,
    input  logic        up_valid,
    input  ccp_window_t up_win,
    output logic        pass_valid,
    output ccp_window_t pass_win
);

    logic        valid_reg;
    ccp_window_t win_reg;
    logic signed [SUM_BITS-1:0] x_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctl.flush)
            valid_reg <= 1'b0;
        else if (ctl.step)
            valid_reg <= ins_here || up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
            win_reg <= ins_here ? ctl.seed : up_win;
    end

    // window after absorbing the current word
    always_comb
    begin
        x_ext    = SUM_BITS'(ctl.sample);
        pass_win = win_reg;
        if (ctl.mode == MODE_AVG)
        begin
            pass_win.acc = win_reg.acc + x_ext;
        end
        else if (x_ext > win_reg.acc)
        begin
            pass_win.acc    = x_ext;
            pass_win.winner = ctl.channel;
        end
        pass_valid = valid_reg;
    end

    `ASSERT_ALWAYS(a_no_collision, !(ctl.step && ins_here && up_valid), "window slot collision")

endmodule

// ===== hdl/ccp_out.sv =====
// ----------------------------------------------------------------------
// ccp_out
// Result pipeline: reciprocal multiply for averages, output register.
// ----------------------------------------------------------------------
`include "assert_macros.svh"

module ccp_out import ccp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   mode,
    input  logic                   res_valid,
    input  ccp_window_t            res_win,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] pooled_value,
    output logic [CH_BITS-1:0]     winner_channel,
    output logic [CH_BITS-1:0]     pooled_channel,
    output logic                   pixel_done
);

    localparam int RECIP_DEPTH = 1 << WIN_LIMIT_BITS;
    localparam int RECIP_SHIFT = SUM_BITS + WIN_LIMIT_BITS;
    localparam int RECIP_BITS  = RECIP_SHIFT + 1;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
    localparam int QUOT_BITS   = PROD_BITS - RECIP_SHIFT;

    logic [RECIP_BITS-1:0] recip_table [RECIP_DEPTH];

    // ceil(2^RECIP_SHIFT / length), exact floor division for the sum range
    for (genvar g = 0; g < RECIP_DEPTH; g++)
    begin : g_recip
        localparam longint unsigned RecipVal =
            ((longint'(1) << RECIP_SHIFT) + longint'(g)) / longint'(g + 1);
        assign recip_table[g] = RECIP_BITS'(RecipVal);
    end

    logic ready_s1, ready_s2, ready_out;

    logic        s1_valid_reg;
    ccp_window_t s1_reg;

    logic                   s2_valid_reg;
    logic [PROD_BITS-1:0]   s2_prod_reg;
    logic                   s2_neg_reg;
    logic [SAMPLE_BITS-1:0] s2_value_reg;
    logic [CH_BITS-1:0]     s2_winner_reg;
    logic [CH_BITS-1:0]     s2_index_reg;
    logic                   s2_done_reg;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] pooled_value_reg;
    logic [CH_BITS-1:0]     winner_channel_reg;
    logic [CH_BITS-1:0]     pooled_channel_reg;
    logic                   pixel_done_reg;

    logic [SUM_BITS-1:0]   mag;
    logic [RECIP_BITS-1:0] recip_sel;
    logic [PROD_BITS-1:0]  prod_next;
    logic [QUOT_BITS-1:0]  quot;
    logic [QUOT_BITS-1:0]  quot_fix;

    assign ready_out = !out_valid_reg || out_ready;
    assign ready_s2  = !s2_valid_reg || ready_out;
    assign ready_s1  = !s1_valid_reg || ready_s2;
    assign in_ready  = ready_s1;

    always_comb
    begin
        mag       = s1_reg.acc[SUM_BITS-1] ? SUM_BITS'(-s1_reg.acc) : SUM_BITS'(s1_reg.acc);
        recip_sel = recip_table[WIN_LIMIT_BITS'(s1_reg.len - LEN_BITS'(1))];
        prod_next = {{RECIP_BITS{1'b0}}, mag} * {{SUM_BITS{1'b0}}, recip_sel};
        quot      = s2_prod_reg[PROD_BITS-1:RECIP_SHIFT];
        quot_fix  = s2_neg_reg ? QUOT_BITS'(-quot) : quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_s1)
                s1_valid_reg <= res_valid;
            if (ready_s2)
                s2_valid_reg <= s1_valid_reg;
            if (ready_out)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_s1 && res_valid)
            s1_reg <= res_win;
        if (ready_s2 && s1_valid_reg)
        begin
            s2_prod_reg   <= prod_next;
            s2_neg_reg    <= s1_reg.acc[SUM_BITS-1];
            s2_value_reg  <= s1_reg.acc[SAMPLE_BITS-1:0];
            s2_winner_reg <= s1_reg.winner;
            s2_index_reg  <= s1_reg.index;
            s2_done_reg   <= s1_reg.done;
        end
        if (ready_out && s2_valid_reg)
        begin
            pooled_value_reg   <= (mode == MODE_AVG) ? quot_fix[SAMPLE_BITS-1:0] : s2_value_reg;
            winner_channel_reg <= (mode == MODE_AVG) ? '0 : s2_winner_reg;
            pooled_channel_reg <= s2_index_reg;
            pixel_done_reg     <= s2_done_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pooled_value   = pooled_value_reg;
    assign winner_channel = winner_channel_reg;
    assign pooled_channel = pooled_channel_reg;
    assign pixel_done     = pixel_done_reg;

    `ASSERT_IMPLY(a_quot_range, s2_valid_reg, quot[QUOT_BITS-1:SAMPLE_BITS] == '0, "quotient overflow")

endmodule

// ===== hdl/cross_channel_pooling.sv =====
// ----------------------------------------------------------------------
// cross_channel_pooling
// Cross-channel max or average pooling over a stream of channel words.
//
// Each input word is one signed Q8.8 channel value of the current pixel,
// in channel order. The block accepts one word per clock cycle whenever
// the output side keeps up; every open window sits in a cell of a row of
// MAX_OPEN_WINDOWS - 1 cells and all of them absorb the word in that same
// cycle. A word that closes a window loads the result register on the edge
// that accepts it; the result then passes the reciprocal multiplier stage
// and the output register, and those three stages also absorb a stall of
// the output. A register write restarts the current pixel; write only
// while no word is in flight.
// ----------------------------------------------------------------------
`include "assert_macros.svh"

module cross_channel_pooling import ccp_pkg::*;
#(
    parameter int MAX_OPEN_WINDOWS = DEF_OPEN_WINDOWS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [SAMPLE_BITS-1:0]    s_tdata,   // sample
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,   // pooled_value, winner_channel, pooled_channel
    output logic                      m_tlast
);

    localparam int NUM_CELLS = (MAX_OPEN_WINDOWS > 1) ? MAX_OPEN_WINDOWS - 1 : 1;

    logic        step;
    ccp_ctrl_t   ctl;
    logic        cell_valid [NUM_CELLS];
    ccp_window_t cell_pass  [NUM_CELLS];

    logic        res_valid;
    ccp_window_t res_win;
    logic        direct_close;

    logic [SAMPLE_BITS-1:0] pooled_value;
    logic [CH_BITS-1:0]     winner_channel;
    logic [CH_BITS-1:0]     pooled_channel;

    assign step = s_tvalid && s_tready;

    ccp_ctrl #(
        .MAX_OPEN_WINDOWS (MAX_OPEN_WINDOWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .sample    (s_tdata),
        .ctl       (ctl)
    );

    for (genvar j = 0; j < NUM_CELLS; j++)
    begin : g_cell
        logic        ins_here;
        logic        up_valid;
        ccp_window_t up_win;

        assign ins_here = ctl.insert && !ctl.direct && (ctl.ins_cell == LEN_BITS'(j));

        if (j == NUM_CELLS - 1)
        begin : g_end
            assign up_valid = 1'b0;
            assign up_win   = '0;
        end
        else
        begin : g_link
            assign up_valid = cell_valid[j+1];
            assign up_win   = cell_pass[j+1];
        end

        ccp_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .ins_here   (ins_here),
            .up_valid   (up_valid),
            .up_win     (up_win),
            .pass_valid (cell_valid[j]),
            .pass_win   (cell_pass[j])
        );
    end

    // single-channel windows close on the word that opens them
    assign direct_close = ctl.insert && ctl.direct;
    assign res_valid    = step && (direct_close || cell_valid[0]);
    assign res_win      = direct_close ? ctl.seed : cell_pass[0];

    ccp_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .mode           (ctl.mode),
        .res_valid      (res_valid),
        .res_win        (res_win),
        .in_ready       (s_tready),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .pooled_value   (pooled_value),
        .winner_channel (winner_channel),
        .pooled_channel (pooled_channel),
        .pixel_done     (m_tlast)
    );

    assign m_tdata = {(OUT_TDATA_BITS - SAMPLE_BITS - 2 * CH_BITS)'(0),
                      pooled_channel, winner_channel, pooled_value};

    `ASSERT_ALWAYS(a_single_close, !(step && direct_close && cell_valid[0]), "two windows closed")
    `ASSERT_IMPLY(a_pixel_end, step && ctl.last_ch && res_valid, res_win.done, "pixel end lost")

endmodule

// ===== test/cross_channel_pooling_tb.sv =====
// ----------------------------------------------------------------------
// cross_channel_pooling_tb
// Self-checking bench for the cross-channel pooling block.
//
// Channel words go in through the input stream with random gaps, and
// the output stream is stalled at random. A local model of the windows
// predicts every pooled word, which the output monitor checks in order.
// Directed tests cover reset settings, max ties, average truncation,
// windows with gaps between them, short pixels, degenerate and saturated
// settings, and a full row of open windows. Random phases with random
// settings follow.
// ----------------------------------------------------------------------
module cross_channel_pooling_tb import ccp_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPEN_WINDOWS = DEF_OPEN_WINDOWS;

    typedef enum logic [CFG_INDEX_BITS-1:0]
    {
        REG_POOL_MODE,
        REG_WINDOW_LENGTH,
        REG_WINDOW_STEP,
        REG_CHANNEL_COUNT
    } reg_index_t;

    typedef struct packed
    {
        logic [SAMPLE_BITS-1:0] pooled_value;
        logic [CH_BITS-1:0]     winner_channel;
        logic [CH_BITS-1:0]     pooled_channel;
        logic                   pixel_done;
    } pooled_word_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [SAMPLE_BITS-1:0]    s_tdata = '0;      // sample
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;           // pooled_value, winner_channel, pooled_channel
    logic                      m_tlast;

    // window model state
    int unsigned  cfg_mode = 0;
    int unsigned  cfg_len = 2;
    int unsigned  cfg_step = 2;
    int unsigned  cfg_count = 64;
    int unsigned  chan_pos = 0;
    longint       window_sum [OPEN_WINDOWS];
    int unsigned  window_best [OPEN_WINDOWS];

    pooled_word_t pending_pools [$];
    int unsigned  mismatches = 0;
    int unsigned  stall_left = 0;
    bit           tx_steady = 1'b0;
    bit           rx_steady = 1'b0;

    cross_channel_pooling i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    function automatic void predict_channel(logic [SAMPLE_BITS-1:0] raw);
        int unsigned  k;
        int unsigned  s;
        int unsigned  n;
        int unsigned  c;
        int unsigned  last;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  first_ch;
        int unsigned  last_ch;
        int unsigned  slot;
        longint       x;
        longint       v;
        pooled_word_t w;
        k = (cfg_len == 0) ? 1 : cfg_len;
        if (k > OPEN_WINDOWS)
            k = OPEN_WINDOWS;
        s = (cfg_step == 0) ? 1 : cfg_step;
        n = (cfg_count == 0) ? 1 : cfg_count;
        if (n > MAX_CHANNELS)
            n = MAX_CHANNELS;
        c = (chan_pos >= n) ? 0 : chan_pos;
        x = longint'($signed(raw));
        last = (n > k) ? (n - k + s - 1) / s : 0;
        if (last > (n - 1) / s)
            last = (n - 1) / s;
        lo = (c >= k) ? (c - k) / s + 1 : 0;
        hi = c / s;
        if (hi > last)
            hi = last;
        for (int unsigned pc = lo; pc <= hi; pc++)
        begin
            first_ch = pc * s;
            last_ch = first_ch + k;
            if (last_ch > n)
                last_ch = n;
            last_ch = last_ch - 1;
            slot = pc % OPEN_WINDOWS;
            if (c == first_ch)
            begin
                window_sum[slot] = x;
                window_best[slot] = c;
            end
            else if (cfg_mode == MODE_AVG)
                window_sum[slot] += x;
            else if (x > window_sum[slot])
            begin
                window_sum[slot] = x;
                window_best[slot] = c;
            end
            if (c == last_ch)
            begin
                v = window_sum[slot];
                if (cfg_mode == MODE_AVG)
                    v = v / longint'(last_ch - first_ch + 1);
                w.pooled_value = v[SAMPLE_BITS-1:0];
                w.winner_channel = (cfg_mode == MODE_AVG) ? '0 : window_best[slot][CH_BITS-1:0];
                w.pooled_channel = pc[CH_BITS-1:0];
                w.pixel_done = (pc == last);
                pending_pools.push_back(w);
            end
        end
        c++;
        if (c >= n)
            c = 0;
        chan_pos = c;
    endfunction

    function automatic void model_write(reg_index_t idx, int unsigned value);
        case (idx)
            REG_POOL_MODE:     cfg_mode = value & 'h1;
            REG_WINDOW_LENGTH: cfg_len = value & 'h7F;
            REG_WINDOW_STEP:   cfg_step = value & 'h7F;
            REG_CHANNEL_COUNT: cfg_count = value & 'h7FF;
        endcase
        chan_pos = 0;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 9))
            6:       return 16'h7FFF;
            7:       return 16'h8000;
            8:       return SAMPLE_BITS'($urandom_range(0, 3));
            9:       return -SAMPLE_BITS'($urandom_range(0, 3));
            default: return SAMPLE_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // one channel word, called at a rising edge
    task automatic send_sample(logic [SAMPLE_BITS-1:0] value);
        int unsigned gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_channel(value);
    endtask

    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_pools.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(int unsigned mode, int unsigned len, int unsigned step,
                             int unsigned count);
        settle_block();
        cfg_we <= 1'b1;
        cfg_index <= REG_POOL_MODE;
        cfg_wdata <= CFG_DATA_BITS'(mode);
        model_write(REG_POOL_MODE, mode);
        @(posedge clk);
        cfg_index <= REG_WINDOW_LENGTH;
        cfg_wdata <= CFG_DATA_BITS'(len);
        model_write(REG_WINDOW_LENGTH, len);
        @(posedge clk);
        cfg_index <= REG_WINDOW_STEP;
        cfg_wdata <= CFG_DATA_BITS'(step);
        model_write(REG_WINDOW_STEP, step);
        @(posedge clk);
        cfg_index <= REG_CHANNEL_COUNT;
        cfg_wdata <= CFG_DATA_BITS'(count);
        model_write(REG_CHANNEL_COUNT, count);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_word();
        pooled_word_t w;
        if (pending_pools.size() == 0)
        begin
            $error("pooled word with nothing expected: tdata %h tlast %b", m_tdata, m_tlast);
            mismatches++;
            return;
        end
        w = pending_pools.pop_front();
        if (m_tdata[SAMPLE_BITS-1:0] !== w.pooled_value)
        begin
            $error("pooled_value expected %h actual %h", w.pooled_value,
                   m_tdata[SAMPLE_BITS-1:0]);
            mismatches++;
        end
        if (m_tdata[SAMPLE_BITS+CH_BITS-1:SAMPLE_BITS] !== w.winner_channel)
        begin
            $error("winner_channel expected %0d actual %0d", w.winner_channel,
                   m_tdata[SAMPLE_BITS+CH_BITS-1:SAMPLE_BITS]);
            mismatches++;
        end
        if (m_tdata[SAMPLE_BITS+2*CH_BITS-1:SAMPLE_BITS+CH_BITS] !== w.pooled_channel)
        begin
            $error("pooled_channel expected %0d actual %0d", w.pooled_channel,
                   m_tdata[SAMPLE_BITS+2*CH_BITS-1:SAMPLE_BITS+CH_BITS]);
            mismatches++;
        end
        if (m_tlast !== w.pixel_done)
        begin
            $error("pixel_done expected %b actual %b", w.pixel_done, m_tlast);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_word();
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 99) < 25)
                    stall_left <= ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
                                                             : $urandom_range(4, 40);
            end
        end
    end

    task automatic test_reset_defaults();
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h7FFE);
        send_sample(16'h7FFF);
    endtask

    task automatic test_max_ties();
        logic [SAMPLE_BITS-1:0] vals [6];
        vals = '{-16'sd5, -16'sd5, 16'sd7, 16'sd7, -16'sd5, -16'sd5};
        configure(MODE_MAX, 3, 2, 6);
        foreach (vals[i])
            send_sample(vals[i]);
    endtask

    task automatic test_avg_truncation();
        logic [SAMPLE_BITS-1:0] vals [5];
        vals = '{-16'sd1, -16'sd2, 16'h7FFF, 16'h7FFF, 16'h8000};
        configure(MODE_AVG, 2, 2, 5);
        foreach (vals[i])
            send_sample(vals[i]);
    endtask

    task automatic test_windows_with_gaps();
        configure(MODE_MAX, 1, 3, 5);
        repeat (5) send_sample(random_sample());
    endtask

    task automatic test_short_pixel();
        configure(MODE_AVG, 8, 2, 3);
        repeat (3) send_sample(random_sample());
    endtask

    task automatic test_degenerate_settings();
        configure(MODE_MAX, 0, 0, 0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
    endtask

    task automatic test_saturated_settings();
        configure(MODE_AVG, 127, 127, 2047);
        repeat (200) send_sample(random_sample());
        configure(MODE_MAX, 64, 1, 1024);
        repeat (100) send_sample(random_sample());
    endtask

    task automatic test_random_pixels();
        int unsigned sent;
        int unsigned r;
        int unsigned mode;
        int unsigned len;
        int unsigned step;
        int unsigned count;
        int unsigned span;
        int unsigned burst;
        sent = 0;
        while (sent < 120)
        begin
            mode = $urandom_range(0, 1);
            r = $urandom_range(0, 99);
            if (r < 5)
                len = 0;
            else if (r < 10)
                len = $urandom_range(65, 127);
            else if (r < 18)
                len = 64;
            else if (r < 30)
                len = $urandom_range(9, 63);
            else
                len = $urandom_range(1, 8);
            r = $urandom_range(0, 99);
            if (r < 5)
                step = 0;
            else if (r < 10)
                step = $urandom_range(65, 127);
            else if (r < 20)
                step = $urandom_range(9, 64);
            else
                step = $urandom_range(1, 8);
            r = $urandom_range(0, 99);
            if (r < 5)
                count = 0;
            else if (r < 10)
                count = $urandom_range(1025, 2047);
            else if (r < 18)
                count = $urandom_range(81, 1024);
            else
                count = $urandom_range(1, 80);
            configure(mode, len, step, count);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            span = (count == 0) ? 1 : ((count > MAX_CHANNELS) ? MAX_CHANNELS : count);
            burst = span * $urandom_range(1, 3);
            if ($urandom_range(0, 1) == 1)
                burst += $urandom_range(0, span - 1);
            if (burst > 48)
                burst = 48;
            repeat (burst) send_sample(random_sample());
            sent += burst;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_max_ties();
        test_avg_truncation();
        test_windows_with_gaps();
        test_short_pixel();
        test_degenerate_settings();
        test_saturated_settings();
        test_random_pixels();
        settle_block();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_pools.size() == 0)
            $display("cross_channel_pooling_tb OK");
        else
            $display("cross_channel_pooling_tb NOT OK");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("cross_channel_pooling_tb NOT OK");
        $finish;
    end

endmodule
